/* rtl/hpd_pkg.sv */
// Shared types, constants and the arctangent table for the haversine path distance unit.
package hpd_pkg;

  localparam int unsigned AtanLen = 40;
  localparam logic signed [63:0] QOne = 64'sd1073741824;
  localparam logic signed [63:0] GainQ30 = 64'sd652032874;
  localparam logic [31:0] PiQ30 = 32'd3373259426;
  localparam logic [23:0] RadiusReset = 24'd1631437;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TRIG_INIT,
    ST_TRIG_STEP,
    ST_MUL,
    ST_SQRT_A,
    ST_SQRT_Q,
    ST_ASIN_STEP,
    ST_PROD,
    ST_SCALE,
    ST_DONE
  } state_e;

  function automatic logic [31:0] atan_turn(input logic [5:0] i);
    logic [31:0] r;
    begin
      case (i)
        6'd0: r = 32'd536870912;
        6'd1: r = 32'd316933406;
        6'd2: r = 32'd167458907;
        6'd3: r = 32'd85004756;
        6'd4: r = 32'd42667331;
        6'd5: r = 32'd21354465;
        6'd6: r = 32'd10679838;
        6'd7: r = 32'd5340245;
        6'd8: r = 32'd2670163;
        6'd9: r = 32'd1335087;
        6'd10: r = 32'd667544;
        6'd11: r = 32'd333772;
        6'd12: r = 32'd166886;
        6'd13: r = 32'd83443;
        6'd14: r = 32'd41722;
        6'd15: r = 32'd20861;
        6'd16: r = 32'd10430;
        6'd17: r = 32'd5215;
        6'd18: r = 32'd2608;
        6'd19: r = 32'd1304;
        6'd20: r = 32'd652;
        6'd21: r = 32'd326;
        6'd22: r = 32'd163;
        6'd23: r = 32'd81;
        6'd24: r = 32'd41;
        6'd25: r = 32'd20;
        6'd26: r = 32'd10;
        6'd27: r = 32'd5;
        6'd28: r = 32'd3;
        6'd29: r = 32'd1;
        6'd30: r = 32'd1;
        default: r = 32'd0;
      endcase
      return r;
    end
  endfunction

endpackage

/* rtl/hpd_cordic.sv */
// Shared CORDIC step unit: one rotation or vectoring micro-rotation per cycle.
module hpd_cordic import hpd_pkg::*; (
  input  logic               vect_i,
  input  logic [5:0]         step_i,
  input  logic signed [63:0] x_i,
  input  logic signed [63:0] y_i,
  input  logic signed [63:0] z_i,
  output logic signed [63:0] x_o,
  output logic signed [63:0] y_o,
  output logic signed [63:0] z_o
);

  logic signed [63:0] dx, dy, at;
  logic               pos;

  always_comb begin
    dx = y_i >>> step_i;
    dy = x_i >>> step_i;
    at = $signed({32'd0, atan_turn(step_i)});
    pos = vect_i ? (y_i > 0) : (z_i >= 0);
    if (pos != vect_i) begin
      x_o = x_i - dx;
      y_o = y_i + dy;
    end else begin
      x_o = x_i + dx;
      y_o = y_i - dy;
    end
    if (vect_i) begin
      z_o = pos ? z_i + at : z_i - at;
    end else begin
      z_o = pos ? z_i - at : z_i + at;
    end
  end

endmodule

/* rtl/hpd_isqrt.sv */
// Bit-serial floor square root, two radicand bits per cycle.
module hpd_isqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] value_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  logic [63:0] rem_q, rem_d, res_q, res_d, bit_q, bit_d;
  logic        busy_q, busy_d;

  always_comb begin
    rem_d = rem_q;
    res_d = res_q;
    bit_d = bit_q;
    busy_d = busy_q;
    if (start_i) begin
      rem_d = value_i;
      res_d = '0;
      bit_d = 64'h4000_0000_0000_0000;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (rem_q >= res_q + bit_q) begin
        rem_d = rem_q - (res_q + bit_q);
        res_d = (res_q >> 1) + bit_q;
      end else begin
        res_d = res_q >> 1;
      end
      bit_d = bit_q >> 2;
      if (bit_q[1:0] != 2'b00) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    res_q <= res_d;
    bit_q <= bit_d;
  end

  assign done_o = !busy_q;
  assign root_o = res_q[31:0];

endmodule

/* rtl/haversine_path_distance_unit.sv */
// Top level of the haversine path distance unit: sequencer, datapath and path state.
//
//  channel  | handshake          | payload
//  in       | in_valid/in_ready  | latitude_i, longitude_i, is_last_i
//  out      | out_valid/out_ready| segment_distance_o, total_distance_o, path_end_o
//  cfg      | cfg_valid/cfg_ready| cfg_data_i (earth radius)
//
// A point after the first raises out_valid after init, four sin/cos runs of CORDIC_STEPS
// steps, the multiply phases, two square roots, an asin run, product and scale.
// A zero haversine term skips asin, product and scale. A first point goes from init
// straight to the result.
// in_ready and cfg_ready are low until the result transaction, high the cycle after.
// Reset clears the stored point, the total and the radius to its default.
module haversine_path_distance_unit import hpd_pkg::*; #(
  parameter int ANGLE_BITS   = 32,
  parameter int TOTAL_BITS   = 48,
  parameter int CORDIC_STEPS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [31:0]    latitude_i,
  input  logic signed [31:0]    longitude_i,
  input  logic                  is_last_i,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [31:0]           segment_distance_o,
  output logic [TOTAL_BITS-1:0] total_distance_o,
  output logic                  path_end_o,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [23:0]           cfg_data_i
);

  localparam int NSteps = (CORDIC_STEPS < 40) ? CORDIC_STEPS : 40;
  localparam logic [5:0] LastStep = 6'(NSteps - 1);
  localparam logic [31:0] Keep = 32'hFFFF_FFFF << (32 - ANGLE_BITS);
  localparam logic [TOTAL_BITS-1:0] TotMax = '1;

  state_e state_q, state_d;
  logic [23:0] radius_q;
  logic [31:0] plat_q, plon_q, lat_q, lon_q;
  logic        have_q, last_q;
  logic [TOTAL_BITS-1:0] total_q;
  logic [31:0] seg_q;
  logic [5:0]  step_q;
  logic [1:0]  trig_q, mul_q;
  logic        flip_q;
  logic signed [63:0] x_q, y_q, z_q;
  logic signed [63:0] s1_q, s2_q, c1_q, c2_q, acc_q;
  logic [31:0] r_q;

  logic signed [63:0] cx, cy, cz, xc, yc;
  logic        vect;
  logic        sq_start, sq_done;
  logic [63:0] sq_val;
  logic [31:0] sq_root;
  logic [31:0] tang, tflip;
  logic        tf;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p;
  logic signed [63:0] a_sum;
  logic [55:0] p_th;
  logic [63:0] dval;
  logic [31:0] seg_sat;
  logic [TOTAL_BITS:0] tsum;

  assign vect = (state_q == ST_ASIN_STEP);

  hpd_cordic u_cordic (
    .vect_i(vect), .step_i(step_q), .x_i(x_q), .y_i(y_q), .z_i(z_q),
    .x_o(cx), .y_o(cy), .z_o(cz)
  );

  hpd_isqrt u_isqrt (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(sq_start), .value_i(sq_val),
    .done_o(sq_done), .root_o(sq_root)
  );

  function automatic logic signed [63:0] clamp1(input logic signed [63:0] v);
    if (v > QOne) return QOne;
    if (v < -QOne) return -QOne;
    return v;
  endfunction

  function automatic logic [31:0] angle_of(input logic [1:0] k);
    logic [31:0] t;
    begin
      unique case (k)
        2'd0: t = lat_q - plat_q;
        2'd1: t = lon_q - plon_q;
        2'd2: t = plat_q;
        default: t = lat_q;
      endcase
      if (k[1] == 1'b0) t = {t[31], t[31:1]};
      return t;
    end
  endfunction

  function automatic logic tang_next_flip(input logic [1:0] k);
    logic [31:0] t;
    begin
      t = angle_of(k + 2'd1);
      return (t + 32'h4000_0000) >= 32'h8000_0000;
    end
  endfunction

  function automatic logic [31:0] tflip_next(input logic [1:0] k);
    logic [31:0] t;
    begin
      t = angle_of(k + 2'd1);
      return ((t + 32'h4000_0000) >= 32'h8000_0000) ? t - 32'h8000_0000 : t;
    end
  endfunction

  always_comb begin
    unique case (trig_q)
      2'd0: tang = lat_q - plat_q;
      2'd1: tang = lon_q - plon_q;
      2'd2: tang = plat_q;
      default: tang = lat_q;
    endcase
    if (trig_q[1] == 1'b0) tang = {tang[31], tang[31:1]};
    tf = (tang + 32'h4000_0000) >= 32'h8000_0000;
    tflip = tf ? tang - 32'h8000_0000 : tang;
    xc = clamp1(cx);
    yc = clamp1(cy);
  end

  // shared multiplier, operands chosen by phase
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (mul_q)
      2'd0: begin mul_a = 32'(s1_q); mul_b = 32'(s1_q); end
      2'd1: begin mul_a = 32'(c1_q); mul_b = 32'(c2_q); end
      2'd2: begin mul_a = 32'(s2_q); mul_b = 32'(s2_q); end
      default: begin mul_a = 32'(acc_q); mul_b = 32'(s2_q); end
    endcase
    mul_p = 64'(mul_a) * 64'(mul_b);
  end

  always_comb begin
    a_sum = s1_q + (mul_p >>> 30);
    if (a_sum < 0) a_sum = '0;
    if (a_sum > QOne) a_sum = QOne;
  end

  assign p_th = 56'(z_q) * 56'(radius_q);
  always_comb begin
    dval = ((64'(x_q[55:22]) * 64'(PiQ30)) + ((64'(x_q[21:0]) * 64'(PiQ30)) >> 22)) >> 30;
    seg_sat = (dval > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : dval[31:0];
    tsum = {1'b0, total_q} + (TOTAL_BITS+1)'(seg_sat);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid) state_d = ST_TRIG_INIT;
      ST_TRIG_INIT: state_d = have_q ? ST_TRIG_STEP : ST_DONE;
      ST_TRIG_STEP: if (step_q == LastStep) state_d = (trig_q == 2'd3) ? ST_MUL : ST_TRIG_STEP;
      ST_MUL: if (mul_q == 2'd3) state_d = ST_SQRT_A;
      ST_SQRT_A: if (sq_done) state_d = ST_SQRT_Q;
      ST_SQRT_Q: if (sq_done) state_d = (r_q == 32'd0) ? ST_DONE : ST_ASIN_STEP;
      ST_ASIN_STEP: if (step_q == LastStep) state_d = ST_PROD;
      ST_PROD: state_d = ST_SCALE;
      ST_SCALE: state_d = ST_DONE;
      ST_DONE: if (out_ready) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state_q == ST_IDLE);
    out_valid = (state_q == ST_DONE);
    cfg_ready = (state_q == ST_IDLE);
    sq_start = 1'b0;
    sq_val = '0;
    if (state_q == ST_MUL && mul_q == 2'd3) begin
      sq_start = 1'b1;
      sq_val = 64'(a_sum) << 30;
    end else if (state_q == ST_SQRT_A && sq_done) begin
      sq_start = 1'b1;
      sq_val = 64'h1000_0000_0000_0000 - 64'(sq_root) * 64'(sq_root);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      radius_q <= RadiusReset;
      plat_q <= '0;
      plon_q <= '0;
      have_q <= 1'b0;
      total_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid && cfg_ready) radius_q <= cfg_data_i;
      if (state_q == ST_DONE && out_ready) begin
        if (last_q) begin
          plat_q <= '0;
          plon_q <= '0;
          have_q <= 1'b0;
          total_q <= '0;
        end else begin
          plat_q <= lat_q;
          plon_q <= lon_q;
          have_q <= 1'b1;
        end
      end
      if (state_q == ST_SCALE) begin
        total_q <= tsum[TOTAL_BITS] ? TotMax : tsum[TOTAL_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        lat_q <= latitude_i & Keep;
        lon_q <= longitude_i & Keep;
        last_q <= is_last_i;
        seg_q <= '0;
        trig_q <= '0;
        step_q <= '0;
        mul_q <= '0;
      end
      ST_TRIG_INIT, ST_TRIG_STEP: begin
        if (state_q == ST_TRIG_INIT) begin
          step_q <= '0;
          x_q <= GainQ30;
          y_q <= '0;
          flip_q <= tf;
          z_q <= 64'($signed(tflip));
        end else if (step_q == LastStep) begin
          unique case (trig_q)
            2'd0: s1_q <= flip_q ? -yc : yc;
            2'd1: s2_q <= flip_q ? -yc : yc;
            2'd2: c1_q <= flip_q ? -xc : xc;
            default: c2_q <= flip_q ? -xc : xc;
          endcase
          trig_q <= trig_q + 2'd1;
          step_q <= '0;
          x_q <= GainQ30;
          y_q <= '0;
          flip_q <= tang_next_flip(trig_q);
          z_q <= 64'($signed(tflip_next(trig_q)));
        end else begin
          x_q <= cx;
          y_q <= cy;
          z_q <= cz;
          step_q <= step_q + 6'd1;
        end
        acc_q <= '0;
      end
      ST_MUL: begin
        unique case (mul_q)
          2'd0: acc_q <= mul_p >>> 30;
          2'd1: begin acc_q <= mul_p >>> 30; s1_q <= acc_q; end
          2'd2: s2_q <= mul_p >>> 30;
          default: acc_q <= a_sum;
        endcase
        mul_q <= mul_q + 2'd1;
      end
      ST_SQRT_A: if (sq_done) r_q <= sq_root;
      ST_SQRT_Q: if (sq_done) begin
        x_q <= 64'(sq_root);
        y_q <= 64'(r_q);
        z_q <= '0;
        step_q <= '0;
      end
      ST_ASIN_STEP: begin
        x_q <= cx;
        y_q <= cy;
        z_q <= (step_q != LastStep) ? cz :
               ((cz < 0) ? 64'sd0 : ((cz > QOne) ? QOne : cz));
        step_q <= step_q + 6'd1;
      end
      ST_PROD: begin
        x_q <= 64'(p_th);
      end
      ST_SCALE: begin
        seg_q <= seg_sat;
      end
      default: ;
    endcase
  end

  assign segment_distance_o = seg_q;
  assign total_distance_o = total_q;
  assign path_end_o = last_q;

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for the haversine path distance unit.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import hpd_pkg::*;

  localparam int Steps = 32;
  localparam int TotBits = 48;
  localparam longint CycleLimit = 4000000;
  localparam longint unsigned TotMax = (64'd1 << TotBits) - 1;
  localparam logic [31:0] AtanTab [40] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
    83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
    81, 41, 20, 10, 5, 3, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0};

  typedef struct {
    logic [31:0] lat;
    logic [31:0] lon;
    logic        last;
  } point_t;

  typedef struct {
    logic [31:0]        seg;
    logic [TotBits-1:0] tot;
    logic               pend;
  } dist_t;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic in_valid = 0, out_ready = 0, cfg_valid = 0;
  logic signed [31:0] latitude_i = 0, longitude_i = 0;
  logic is_last_i = 0;
  logic [23:0] cfg_data_i = 0;
  logic in_ready, out_valid, cfg_ready, path_end_o;
  logic [31:0] segment_distance_o;
  logic [TotBits-1:0] total_distance_o;

  point_t pending_pts[$];
  dist_t  dist_q[$];
  logic [23:0] radius_m = RadiusReset;
  logic [31:0] prev_lat = 0, prev_lon = 0;
  logic has_prev = 0;
  longint unsigned run_tot = 0;
  bit in_taken = 0;
  bit failed = 0;
  int mode = 0;
  int hold_left = 0;
  bit hold_go = 0;
  bit hold_done = 0;
  longint cycles = 0;

  haversine_path_distance_unit uut (
    .clk_i, .rst_ni, .in_valid, .in_ready, .latitude_i, .longitude_i, .is_last_i,
    .out_valid, .out_ready, .segment_distance_o, .total_distance_o, .path_end_o,
    .cfg_valid, .cfg_ready, .cfg_data_i);

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned res, bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > v) bt >>= 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v -= res + bt;
        res = (res >> 1) + bt;
      end else begin
        res >>= 1;
      end
      bt >>= 2;
    end
    return res;
  endfunction

  function automatic longint clamp_q30(longint v);
    if (v > QOne) return QOne;
    if (v < -QOne) return -QOne;
    return v;
  endfunction

  function automatic void rotate_trig(input logic [31:0] t, output longint s,
                                      output longint c);
    logic flip;
    longint x, y, z, dx, dy;
    logic [31:0] sum;
    sum = t + 32'h40000000;
    flip = sum >= 32'h80000000;
    if (flip) t = t - 32'h80000000;
    x = GainQ30;
    y = 0;
    z = longint'(signed'(t));
    for (int i = 0; i < Steps; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(AtanTab[i]);
      end else begin
        x += dx; y -= dy; z += longint'(AtanTab[i]);
      end
    end
    x = clamp_q30(x);
    y = clamp_q30(y);
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic logic [31:0] arc_length(logic [31:0] la1, logic [31:0] lo1,
                                             logic [31:0] la2, logic [31:0] lo2,
                                             logic [23:0] rad);
    longint s1, s2, c1, c2, nu, a, x, y, z, dx, dy;
    longint unsigned r, q, p, hi, lo, d;
    logic [31:0] dl;
    dl = la2 - la1;
    rotate_trig({dl[31], dl[31:1]}, s1, nu);
    dl = lo2 - lo1;
    rotate_trig({dl[31], dl[31:1]}, s2, nu);
    rotate_trig(la1, nu, c1);
    rotate_trig(la2, nu, c2);
    a = ((s1 * s1) >>> 30) + ((((c1 * c2) >>> 30) * ((s2 * s2) >>> 30)) >>> 30);
    if (a < 0) a = 0;
    if (a > QOne) a = QOne;
    r = floor_sqrt(longint'(a) << 30);
    if (r == 0) return 0;
    q = floor_sqrt((64'd1 << 60) - r * r);
    x = q; y = r; z = 0;
    for (int i = 0; i < Steps; i++) begin
      dx = x;
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += longint'(AtanTab[i]);
      end else begin
        x -= dx; y += dy; z -= longint'(AtanTab[i]);
      end
    end
    if (z < 0) z = 0;
    if (z > QOne) z = QOne;
    p = longint'(z) * longint'(rad);
    hi = p >> 22;
    lo = p & ((64'd1 << 22) - 1);
    d = (hi * PiQ30 + ((lo * PiQ30) >> 22)) >> 30;
    return d > 64'hFFFFFFFF ? 32'hFFFFFFFF : d[31:0];
  endfunction

  task automatic track_point(point_t pt);
    dist_t e;
    logic [31:0] sg;
    sg = 0;
    if (has_prev) begin
      sg = arc_length(prev_lat, prev_lon, pt.lat, pt.lon, radius_m);
      if (run_tot > TotMax || TotMax - run_tot < sg) run_tot = TotMax;
      else run_tot += sg;
    end
    e.seg = sg;
    e.tot = run_tot[TotBits-1:0];
    e.pend = pt.last;
    dist_q.push_back(e);
    if (pt.last) begin
      prev_lat = 0; prev_lon = 0; has_prev = 0; run_tot = 0;
    end else begin
      prev_lat = pt.lat; prev_lon = pt.lon; has_prev = 1;
    end
  endtask

  // monitor: sample at rising edge
  always @(posedge clk_i) begin
    dist_t e;
    point_t pt;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
    in_taken = in_valid && in_ready;
    if (rst_ni && cfg_valid && cfg_ready) radius_m = cfg_data_i;
    if (rst_ni && in_taken) begin
      pt.lat = latitude_i; pt.lon = longitude_i; pt.last = is_last_i;
      track_point(pt);
    end
    if (rst_ni && out_valid && out_ready) begin
      if (dist_q.size() == 0) begin
        $display("%0t unexpected transaction seg=%0d tot=%0d end=%0b", $time,
                 segment_distance_o, total_distance_o, path_end_o);
        failed = 1;
      end else begin
        e = dist_q.pop_front();
        if (e.seg !== segment_distance_o) begin
          $display("%0t segment exp=%0d act=%0d", $time, e.seg, segment_distance_o);
          failed = 1;
        end
        if (e.tot !== total_distance_o) begin
          $display("%0t total exp=%0d act=%0d", $time, e.tot, total_distance_o);
          failed = 1;
        end
        if (e.pend !== path_end_o) begin
          $display("%0t path_end exp=%0b act=%0b", $time, e.pend, path_end_o);
          failed = 1;
        end
      end
    end
  end

  // driver: change at falling edge
  always @(negedge clk_i) begin
    point_t pt;
    int idle_tx, idle_rx;
    idle_tx = (mode == 0) ? 30 : (mode == 1) ? 67 : 0;
    idle_rx = (mode == 0) ? 67 : (mode == 1) ? 30 : 0;
    if (!in_valid || in_taken) begin
      if (pending_pts.size() > 0 && $urandom_range(99) >= idle_tx) begin
        pt = pending_pts.pop_front();
        latitude_i <= pt.lat;
        longitude_i <= pt.lon;
        is_last_i <= pt.last;
        in_valid <= 1;
      end else begin
        in_valid <= 0;
      end
    end
    out_ready <= (hold_left == 0) && ($urandom_range(99) >= idle_rx);
  end

  always @(negedge clk_i) begin
    if (hold_left > 0) hold_left <= hold_left - 1;
    else if (hold_go && !hold_done) begin
      hold_left <= 1500;
      hold_done <= 1;
    end
  end

  task automatic add_pt(logic [31:0] la, logic [31:0] lo, logic la_st);
    point_t pt;
    pt.lat = la; pt.lon = lo; pt.last = la_st;
    pending_pts.push_back(pt);
  endtask

  task automatic drain();
    while (pending_pts.size() > 0 || in_valid || dist_q.size() > 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic write_radius(logic [23:0] v);
    @(negedge clk_i);
    cfg_data_i <= v;
    cfg_valid <= 1;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid <= 0;
  endtask

  function automatic logic [31:0] rand_lat();
    return 32'($urandom_range(32'h80000000)) - 32'h40000000;
  endfunction

  task automatic random_paths(int n);
    int len;
    logic [31:0] la, lo;
    while (n > 0) begin
      len = $urandom_range(1, 8);
      la = rand_lat();
      lo = $urandom;
      for (int k = 0; k < len && n > 0; k++) begin
        case ($urandom_range(3))
          0: begin la = rand_lat(); lo = $urandom; end
          1: begin la = la + 32'($urandom_range(65535)) - 32768;
                   lo = lo + 32'($urandom_range(1 << 20)) - (1 << 19); end
          2: begin la = $urandom; lo = $urandom; end
          default: begin la = la ^ (32'd1 << $urandom_range(31));
                         lo = lo ^ (32'd1 << $urandom_range(31)); end
        endcase
        add_pt(la, lo, (k == len - 1) || ($urandom_range(19) == 0));
        n--;
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;
    mode = 2;
    add_pt(0, 0, 1);
    add_pt(32'h40000000, 32'h7FFFFFFF, 0);
    add_pt(32'hC0000000, 32'h80000000, 1);
    add_pt(0, 0, 0);
    add_pt(0, 0, 0);
    add_pt(0, 32'h80000000, 0);
    add_pt(32'h40000000, 0, 0);
    add_pt(32'h7FFFFFFF, 32'hFFFFFFFF, 0);
    add_pt(32'h80000000, 32'h00000001, 0);
    add_pt(32'h00000001, 32'h00000000, 1);
    drain();
    write_radius(24'hFFFFFF);
    add_pt(32'h40000000, 0, 0);
    add_pt(32'hC0000000, 0, 0);
    add_pt(0, 32'h80000000, 0);
    add_pt(32'h40000000, 32'h40000000, 1);
    drain();
    write_radius(24'd0);
    add_pt(32'h12345678, 32'h9ABCDEF0, 0);
    add_pt(32'hEDCBA987, 32'h6543210F, 1);
    drain();
    write_radius(RadiusReset);
    mode = 0;
    random_paths(600);
    hold_go = 1;
    drain();
    write_radius(24'($urandom));
    mode = 1;
    random_paths(600);
    drain();
    write_radius(24'hFFFFFF);
    mode = 2;
    random_paths(300);
    drain();
    write_radius(24'($urandom));
    random_paths(300);
    drain();
    if (!failed) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
